// ===== rtl/clipped_offset_span_translator_assert.svh =====
// assertion macros shared by the checker
`ifndef CLIPPED_OFFSET_SPAN_TRANSLATOR_ASSERT_SVH
`define CLIPPED_OFFSET_SPAN_TRANSLATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define COST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define COST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/cost_pkg.sv =====
`default_nettype none
package cost_pkg;
	localparam int Depth = 64;
	localparam int IdxW = 6;
	localparam int CntW = 7;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StOod = 2'd1;
	localparam logic [1:0] StMisorder = 2'd2;
	localparam logic [1:0] StFull = 2'd3;

	// one table segment
	typedef struct packed {
		logic [31:0] clip_lo;
		logic [31:0] clip_hi;
		logic [31:0] orig_lo;
		logic [31:0] orig_hi;
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEARCH,
		ST_FETCH,
		ST_DONE
	} fsm_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic           write;
		logic [IdxW-1:0] widx;
		seg_t           wdata;
		logic           shift;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/cost_cell.sv =====
`default_nettype none
// one segment slot of the ring: loads on its index, rotates on shift, holds otherwise
module cost_cell (
	input  wire logic                          clk,
	input  wire logic [cost_pkg::IdxW-1:0]     idx,
	input  wire cost_pkg::cell_ctl_t           ctl,
	input  wire cost_pkg::seg_t                prev,
	output cost_pkg::seg_t                     seg
);
	cost_pkg::seg_t seg_q;

	// segment storage, rotates one position per shift
	always_ff @(posedge clk) begin
		if (ctl.write && ctl.widx == idx && !ctl.shift) begin
			seg_q <= ctl.wdata;
		end else if (ctl.shift) begin
			seg_q <= prev;
		end
	end

	assign seg = seg_q;
endmodule
`default_nettype wire

// ===== rtl/clipped_offset_span_translator.sv =====
`default_nettype none
// add span: the result beat is shown in the cycle after the start beat
// map span: the start beat is followed by the SCAN, SEARCH and FETCH states, then the result beat
// SCAN and FETCH each make one full rotation of the 64-cell ring, SEARCH runs the binary search probes
// the receiver cannot stall, busy holds off the next start until after the result beat
// reset: segment count cleared, table contents undefined until written
module clipped_offset_span_translator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [31:0] span_start,
	input  wire logic [31:0] span_end,
	input  wire logic [6:0]  window_low,
	input  wire logic [6:0]  window_high,
	output logic             done,
	output logic [31:0]      mapped_start,
	output logic [31:0]      mapped_end,
	output logic [1:0]       status,
	output logic [6:0]       next_window_low,
	output logic [6:0]       next_window_high,
	output logic [6:0]       entry_count
);
	localparam int D = cost_pkg::Depth;
	localparam int IW = cost_pkg::IdxW;
	localparam int CW = cost_pkg::CntW;

	cost_pkg::fsm_t state_q, state_d;
	cost_pkg::cell_ctl_t ctl;
	cost_pkg::seg_t segs [D];
	cost_pkg::seg_t last_q;

	logic [CW-1:0] cnt_q;
	logic          mode_q;
	logic [31:0]   s_q, e_q;
	logic [CW-1:0] wl_q, wh_q;
	logic [CW-1:0] pos_q;
	logic [1:0]    st_add_q;
	// comparison bits per entry: clipped end below e, clipped start not above s
	logic [D-1:0]  chi_lt_q, clo_le_q;
	// search a: lower bound on clipped ends, search b: upper bound on clipped starts
	logic [CW-1:0] a_first_q, a_len_q, b_first_q, b_len_q;
	logic          again_q;
	cost_pkg::seg_t a_seg_q, b_seg_q;

	// ring of cells, head at index 0
	for (genvar i = 0; i < D; i++) begin : g_cell
		cost_cell u_cell (
			.clk(clk), .idx(IW'(i)), .ctl(ctl),
			.prev(segs[(i + 1) % D]), .seg(segs[i])
		);
	end

	cost_pkg::seg_t head;
	assign head = segs[0];
	logic [IW-1:0] pidx;
	assign pidx = pos_q[IW-1:0];

	// clamped window
	logic [CW-1:0] wl_c, wh_c;
	always_comb begin
		wl_c = (window_low > cnt_q) ? cnt_q : window_low;
		wh_c = (window_high > cnt_q) ? cnt_q : window_high;
		if (wl_c > wh_c) wh_c = wl_c;
	end

	// add-span decision
	logic [31:0] len;
	logic [1:0]  add_st;
	logic        add_wr;
	logic [CW-1:0] add_cnt;
	cost_pkg::seg_t add_seg;
	logic [IW-1:0] add_idx;
	always_comb begin
		len = span_end - span_start;
		add_st = cost_pkg::StOk;
		add_wr = 1'b0;
		add_cnt = cnt_q;
		add_seg = last_q;
		add_idx = IW'(cnt_q - 7'd1);
		if (cnt_q == '0) begin
			add_wr = 1'b1;
			add_idx = '0;
			add_seg = '{32'd0, len, span_start, span_end};
			add_cnt = 7'd1;
		end else if (last_q.orig_hi < span_start) begin
			if (cnt_q >= CW'(D)) begin
				add_st = cost_pkg::StFull;
			end else begin
				add_wr = 1'b1;
				add_idx = cnt_q[IW-1:0];
				add_seg.clip_lo = last_q.clip_hi + 32'd1;
				add_seg.clip_hi = last_q.clip_hi + 32'd1 + len;
				add_seg.orig_lo = span_start;
				add_seg.orig_hi = span_end;
				add_cnt = cnt_q + 7'd1;
			end
		end else if (last_q.orig_hi < span_end) begin
			if (span_start < last_q.orig_lo) begin
				add_st = cost_pkg::StMisorder;
			end else begin
				add_wr = 1'b1;
				add_seg.clip_hi = last_q.clip_hi + (span_end - last_q.orig_hi);
				add_seg.orig_hi = span_end;
			end
		end
	end

	// binary search probes, one step per cycle
	logic [CW-1:0] a_half, a_mid, b_half, b_mid;
	logic          a_go, b_go, srch_idle, retry;
	always_comb begin
		a_half = a_len_q >> 1;
		a_mid = a_first_q + a_half;
		a_go = !a_mid[CW-1] && chi_lt_q[a_mid[IW-1:0]];
		b_half = b_len_q >> 1;
		b_mid = b_first_q + b_half;
		b_go = !b_mid[CW-1] && clo_le_q[b_mid[IW-1:0]];
		srch_idle = (a_len_q == '0) && (b_len_q == '0);
		// empty span with nothing in the window searches again from the window start
		retry = (s_q == e_q) && !again_q && (a_first_q == wh_q);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			cost_pkg::ST_IDLE: begin
				if (start && mode) state_d = cost_pkg::ST_SCAN;
				else if (start) begin
					state_d = cost_pkg::ST_DONE;
					ctl.write = add_wr;
					ctl.widx = add_idx;
					ctl.wdata = add_seg;
				end
			end
			cost_pkg::ST_SCAN: begin
				ctl.shift = 1'b1;
				if (pos_q == CW'(D - 1)) state_d = cost_pkg::ST_SEARCH;
			end
			cost_pkg::ST_SEARCH: begin
				if (srch_idle && !retry) state_d = cost_pkg::ST_FETCH;
			end
			cost_pkg::ST_FETCH: begin
				ctl.shift = 1'b1;
				if (pos_q == CW'(D - 1)) state_d = cost_pkg::ST_DONE;
			end
			cost_pkg::ST_DONE: state_d = cost_pkg::ST_IDLE;
			default: state_d = cost_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cost_pkg::ST_IDLE;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cost_pkg::ST_IDLE && start && !mode) cnt_q <= add_cnt;
			if (state_q == cost_pkg::ST_SCAN || state_q == cost_pkg::ST_FETCH)
				pos_q <= pos_q + 7'd1;
			else pos_q <= '0;
		end
	end

	// accepted beat, comparison scan, search steps and segment fetch
	always_ff @(posedge clk) begin
		if (state_q == cost_pkg::ST_IDLE && start) begin
			mode_q <= mode;
			s_q <= span_start;
			e_q <= span_end;
			wl_q <= wl_c;
			wh_q <= wh_c;
			st_add_q <= add_st;
			again_q <= 1'b0;
			b_first_q <= '0;
			if (span_start == span_end) begin
				a_first_q <= wl_c;
				a_len_q <= wh_c - wl_c;
				b_len_q <= '0;
			end else begin
				a_first_q <= '0;
				a_len_q <= cnt_q;
				b_len_q <= cnt_q;
			end
			if (!mode && add_wr) last_q <= add_seg;
		end else if (state_q == cost_pkg::ST_SCAN) begin
			chi_lt_q[pidx] <= head.clip_hi < e_q;
			clo_le_q[pidx] <= !(s_q < head.clip_lo);
		end else if (state_q == cost_pkg::ST_SEARCH) begin
			if (a_len_q != '0) begin
				if (a_go) begin
					a_first_q <= a_mid + 7'd1;
					a_len_q <= a_len_q - a_half - 7'd1;
				end else begin
					a_len_q <= a_half;
				end
			end
			if (b_len_q != '0) begin
				if (b_go) begin
					b_first_q <= b_mid + 7'd1;
					b_len_q <= b_len_q - b_half - 7'd1;
				end else begin
					b_len_q <= b_half;
				end
			end
			if (srch_idle && retry) begin
				a_first_q <= wl_q;
				a_len_q <= cnt_q - wl_q;
				again_q <= 1'b1;
			end
		end else if (state_q == cost_pkg::ST_FETCH) begin
			if (pos_q == a_first_q) a_seg_q <= head;
			if (pos_q == b_first_q - 7'd1) b_seg_q <= head;
		end
	end

	// result forming
	logic [31:0] r_ms, r_me;
	logic [1:0]  r_st;
	logic [CW-1:0] r_wl, r_wh;
	always_comb begin
		r_ms = '0; r_me = '0; r_st = cost_pkg::StOk; r_wl = '0; r_wh = cnt_q;
		if (!mode_q) begin
			r_st = st_add_q;
		end else if (s_q == e_q) begin
			if (a_first_q >= cnt_q || a_first_q >= CW'(D) || s_q < a_seg_q.clip_lo)
				r_st = cost_pkg::StOod;
			else begin
				r_ms = a_seg_q.orig_lo + (s_q - a_seg_q.clip_lo);
				r_me = r_ms;
				r_wl = a_first_q;
				r_wh = a_first_q + 7'd1;
			end
		end else if (b_first_q == '0 || b_first_q > CW'(D) ||
				s_q < b_seg_q.clip_lo || s_q > b_seg_q.clip_hi ||
				a_first_q >= cnt_q || a_first_q >= CW'(D) ||
				e_q < a_seg_q.clip_lo || e_q > a_seg_q.clip_hi) begin
			r_st = cost_pkg::StOod;
		end else begin
			r_ms = b_seg_q.orig_lo + (s_q - b_seg_q.clip_lo);
			r_me = a_seg_q.orig_lo + (e_q - a_seg_q.clip_lo);
			r_wl = b_first_q - 7'd1;
			r_wh = a_first_q;
		end
	end

	assign busy = state_q != cost_pkg::ST_IDLE;
	assign done = state_q == cost_pkg::ST_DONE;
	assign mapped_start = r_ms;
	assign mapped_end = r_me;
	assign status = r_st;
	assign next_window_low = r_wl;
	assign next_window_high = r_wh;
	assign entry_count = cnt_q;
endmodule
`default_nettype wire

// ===== rtl/cost_checker.sv =====
`default_nettype none
`include "clipped_offset_span_translator_assert.svh"
// port-level checks on the command handshake and the entry count
module cost_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [1:0] status,
	input wire logic [6:0] entry_count
);
	// a beat taken makes the block busy
	`COST_ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy)
	// a result strobe lasts one cycle
	`COST_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	// done only while busy
	`COST_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	// count never exceeds the table
	`COST_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, entry_count <= 7'd64)
	// a full table reports full count
	`COST_ASSERT_IMP(a_full_cnt, clk, arst_n, done && status == cost_pkg::StFull, entry_count == 7'd64)
endmodule

bind clipped_offset_span_translator cost_checker u_cost_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .entry_count(entry_count)
);
`default_nettype wire
